// File: design/kmbd_pkg.sv
// shared types and constants of the keyboard and mouse byte decoder
// no dependencies

package kmbd_pkg;

   localparam int CMD_FIFO_DEPTH = 2;

   localparam logic [1:0] FUNC_BYTE = 2'd0;
   localparam logic [1:0] FUNC_TICK = 2'd1;
   localparam logic [1:0] FUNC_POP  = 2'd2;

   localparam logic [1:0] CSR_HEADER_PATTERN = 2'd0;
   localparam logic [1:0] CSR_MAX_X          = 2'd1;
   localparam logic [1:0] CSR_MAX_Y          = 2'd2;
   localparam logic [1:0] CSR_REPEAT_PERIOD  = 2'd3;

   localparam logic [7:0] HEADER_PATTERN_RESET = 8'hF8;
   localparam logic [9:0] MAX_X_RESET          = 10'd631;
   localparam logic [8:0] MAX_Y_RESET          = 9'd393;
   localparam logic [3:0] REPEAT_PERIOD_RESET  = 4'd9;
   localparam logic [9:0] POS_X_RESET          = 10'd320;
   localparam logic [8:0] POS_Y_RESET          = 9'd75;

   localparam logic [1:0] PHASE_HEADER = 2'd0;
   localparam logic [1:0] PHASE_X      = 2'd1;
   localparam logic [1:0] PHASE_Y      = 2'd2;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_MAKE,
      OP_BREAK,
      OP_TICK,
      OP_POP
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [6:0] code;
      logic [9:0] mouse_x;
      logic [8:0] mouse_y;
      logic       left_button;
      logic       right_button;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TICK_B,
      ST_POP_DATA
   } back_state_type;

endpackage

// File: design/kmbd_ram.sv
// generic single write port ram with registered read
// no dependencies

module kmbd_ram #(
   parameter int WIDTH = 7,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/kmbd_front.sv
// front end: accepts requests, tracks mouse packets, classifies key bytes
// depends on kmbd_pkg

module kmbd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_func,
   input  logic [7:0]        req_data,
   input  logic [7:0]        header_pattern,
   input  logic [9:0]        max_x,
   input  logic [8:0]        max_y,
   input  logic              fifo_full,
   output logic              cmd_push,
   output kmbd_pkg::cmd_type cmd
);
   import kmbd_pkg::*;

   logic [1:0]  phase_ff, phase_in;
   logic [9:0]  pos_x_ff, pos_x_in;
   logic [8:0]  pos_y_ff, pos_y_in;
   logic        left_ff, left_in;
   logic        right_ff, right_in;
   logic [11:0] sum_x;
   logic [10:0] sum_y;
   logic        accept;
   logic        is_mouse;

   assign req_ready = !fifo_full;
   assign accept    = req_valid && req_ready;
   assign cmd_push  = accept;

   assign sum_x = {2'b00, pos_x_ff} + {{4{req_data[7]}}, req_data};
   assign sum_y = {2'b00, pos_y_ff} + {{3{req_data[7]}}, req_data};
   assign is_mouse = ((req_data & header_pattern) == header_pattern) ||
                     (phase_ff != PHASE_HEADER);

   always_comb begin
      phase_in = phase_ff;
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      left_in  = left_ff;
      right_in = right_ff;
      cmd.op   = OP_NONE;
      cmd.code = req_data[6:0];
      case (req_func)
         FUNC_BYTE: begin
            if (is_mouse) begin
               case (phase_ff)
                  PHASE_HEADER: begin
                     left_in  = req_data[1];
                     right_in = req_data[0];
                     phase_in = PHASE_X;
                  end
                  PHASE_X: begin
                     if (sum_x[11]) begin
                        pos_x_in = '0;
                     end else if (sum_x[10:0] > {1'b0, max_x}) begin
                        pos_x_in = max_x;
                     end else begin
                        pos_x_in = sum_x[9:0];
                     end
                     phase_in = PHASE_Y;
                  end
                  PHASE_Y: begin
                     if (sum_y[10]) begin
                        pos_y_in = '0;
                     end else if (sum_y[9:0] > {1'b0, max_y}) begin
                        pos_y_in = max_y;
                     end else begin
                        pos_y_in = sum_y[8:0];
                     end
                     phase_in = PHASE_HEADER;
                  end
                  default: begin
                     phase_in = PHASE_HEADER;
                  end
               endcase
            end else if (req_data[7]) begin
               cmd.op = OP_BREAK;
            end else begin
               cmd.op = OP_MAKE;
            end
         end
         FUNC_TICK: cmd.op = OP_TICK;
         FUNC_POP:  cmd.op = OP_POP;
         default:   cmd.op = OP_NONE;
      endcase
      cmd.mouse_x      = pos_x_in;
      cmd.mouse_y      = pos_y_in;
      cmd.left_button  = left_in;
      cmd.right_button = right_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_HEADER;
         pos_x_ff <= POS_X_RESET;
         pos_y_ff <= POS_Y_RESET;
         left_ff  <= 1'b0;
         right_ff <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         left_ff  <= left_in;
         right_ff <= right_in;
      end
   end

endmodule

// File: design/kmbd_cmd_fifo.sv
// two entry command queue between front and back end
// depends on kmbd_pkg

module kmbd_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  kmbd_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output kmbd_pkg::cmd_type head_cmd
);
   import kmbd_pkg::*;

   localparam int PW = $clog2(CMD_FIFO_DEPTH);
   localparam int CW = $clog2(CMD_FIFO_DEPTH + 1);

   cmd_type       entry_ff [CMD_FIFO_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full       = (count_ff == CW'(CMD_FIFO_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: design/kmbd_back.sv
// back end: held keys, auto repeat, key queue and response register
// depends on kmbd_pkg and kmbd_ram

module kmbd_back #(
   parameter int QUEUE_DEPTH = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  kmbd_pkg::cmd_type cmd,
   output logic              cmd_pop,
   input  logic [3:0]        repeat_period,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_key_valid,
   output logic [6:0]        rsp_key_code,
   output logic [7:0]        rsp_keys_waiting,
   output logic              rsp_overflow,
   output logic [9:0]        rsp_mouse_x,
   output logic [8:0]        rsp_mouse_y,
   output logic              rsp_left_button,
   output logic              rsp_right_button
);
   import kmbd_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   back_state_type state_ff, state_in;
   logic          held_a_ff, held_a_in, held_b_ff, held_b_in;
   logic [6:0]    code_a_ff, code_a_in, code_b_ff, code_b_in;
   logic [3:0]    cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic [AW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic          drop_ff, drop_in;

   logic          rsp_valid_ff;
   logic          key_valid_ff;
   logic [6:0]    key_code_ff;
   logic [7:0]    keys_waiting_ff;
   logic          overflow_ff;
   logic [9:0]    mouse_x_ff;
   logic [8:0]    mouse_y_ff;
   logic          left_ff, right_ff;

   logic          out_free, finish, key_valid_n, overflow_n, dropped;
   logic          enq_req;
   logic [6:0]    enq_code;
   logic          wr_en, rd_en;
   logic [6:0]    rd_data;
   logic [CW+7:0] waiting_wide;

   assign out_free = !rsp_valid_ff || rsp_ready;

   kmbd_ram #(
      .WIDTH(7),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (enq_code),
      .rd_en   (rd_en),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in    = state_ff;
      held_a_in   = held_a_ff;
      held_b_in   = held_b_ff;
      code_a_in   = code_a_ff;
      code_b_in   = code_b_ff;
      cnt_a_in    = cnt_a_ff;
      cnt_b_in    = cnt_b_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      drop_in     = drop_ff;
      finish      = 1'b0;
      cmd_pop     = 1'b0;
      key_valid_n = 1'b0;
      enq_req     = 1'b0;
      enq_code    = cmd.code;
      rd_en       = 1'b0;
      wr_en       = 1'b0;
      dropped     = 1'b0;
      overflow_n  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd.op)
                  OP_MAKE: begin
                     if (out_free) begin
                        if (!held_a_ff) begin
                           code_a_in = cmd.code;
                           held_a_in = 1'b1;
                        end else begin
                           code_b_in = cmd.code;
                           held_b_in = 1'b1;
                        end
                        enq_req = 1'b1;
                        finish  = 1'b1;
                     end
                  end
                  OP_BREAK: begin
                     if (out_free) begin
                        if (cmd.code == code_a_ff) begin
                           held_a_in = 1'b0;
                        end else if (cmd.code == code_b_ff) begin
                           held_b_in = 1'b0;
                        end
                        finish = 1'b1;
                     end
                  end
                  OP_TICK: begin
                     if (!held_a_ff) begin
                        cnt_a_in = '0;
                     end else if (cnt_a_ff < repeat_period) begin
                        cnt_a_in = cnt_a_ff + 4'd1;
                     end else begin
                        cnt_a_in = '0;
                        enq_req  = 1'b1;
                        enq_code = code_a_ff;
                     end
                     state_in = ST_TICK_B;
                  end
                  OP_POP: begin
                     if (count_ff != '0) begin
                        rd_en    = 1'b1;
                        head_in  = (head_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + AW'(1);
                        count_in = count_ff - CW'(1);
                        state_in = ST_POP_DATA;
                     end else if (out_free) begin
                        finish = 1'b1;
                     end
                  end
                  default: begin
                     finish = out_free;
                  end
               endcase
            end
         end
         ST_TICK_B: begin
            if (out_free) begin
               if (!held_b_ff) begin
                  cnt_b_in = '0;
               end else if (cnt_b_ff < repeat_period) begin
                  cnt_b_in = cnt_b_ff + 4'd1;
               end else begin
                  cnt_b_in = '0;
                  enq_req  = 1'b1;
                  enq_code = code_b_ff;
               end
               finish   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_POP_DATA: begin
            if (out_free) begin
               key_valid_n = 1'b1;
               finish      = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (enq_req) begin
         if (count_ff == CW'(QUEUE_DEPTH)) begin
            dropped = 1'b1;
         end else begin
            wr_en    = 1'b1;
            tail_in  = (tail_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + AW'(1);
            count_in = count_ff + CW'(1);
         end
      end

      if (state_ff == ST_TICK_B) begin
         overflow_n = drop_ff || dropped;
      end else begin
         overflow_n = dropped;
         drop_in    = dropped;
      end
      cmd_pop = finish;
   end

   assign waiting_wide = {8'b0, count_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         held_a_ff    <= 1'b0;
         held_b_ff    <= 1'b0;
         code_a_ff    <= '0;
         code_b_ff    <= '0;
         cnt_a_ff     <= '0;
         cnt_b_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_a_ff    <= held_a_in;
         held_b_ff    <= held_b_in;
         code_a_ff    <= code_a_in;
         code_b_ff    <= code_b_in;
         cnt_a_ff     <= cnt_a_in;
         cnt_b_ff     <= cnt_b_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         key_valid_ff    <= key_valid_n;
         key_code_ff     <= key_valid_n ? rd_data : 7'd0;
         keys_waiting_ff <= waiting_wide[7:0];
         overflow_ff     <= overflow_n;
         mouse_x_ff      <= cmd.mouse_x;
         mouse_y_ff      <= cmd.mouse_y;
         left_ff         <= cmd.left_button;
         right_ff        <= cmd.right_button;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_key_valid    = key_valid_ff;
   assign rsp_key_code     = key_code_ff;
   assign rsp_keys_waiting = keys_waiting_ff;
   assign rsp_overflow     = overflow_ff;
   assign rsp_mouse_x      = mouse_x_ff;
   assign rsp_mouse_y      = mouse_y_ff;
   assign rsp_left_button  = left_ff;
   assign rsp_right_button = right_ff;

endmodule

// File: design/keyboard_mouse_byte_decoder.sv
// top level of the keyboard and mouse byte decoder
// depends on kmbd_pkg, kmbd_front, kmbd_cmd_fifo, kmbd_back
//
//   port group   direction   handshake           payload
//   req_         in          req_valid/ready     func, data
//   rsp_         out         rsp_valid/ready     key, queue fill, overflow, mouse state
//   csr_         in          csr_we              csr_index, csr_wdata
//
// a byte, break, make, ignored item or pop of an empty queue finishes in ST_IDLE
// a tick passes through ST_IDLE and ST_TICK_B: up to two key queue writes through the single ram write port
// a pop of a filled queue passes through ST_POP_DATA: the key queue ram read is registered
// synchronous reset; key queue contents are not cleared and are never read unwritten
// a two entry command queue lets requests enter while a response waits on rsp_ready

module keyboard_mouse_byte_decoder #(
   parameter int QUEUE_DEPTH = 128
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_func,
   input  logic [7:0] req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_key_valid,
   output logic [6:0] rsp_key_code,
   output logic [7:0] rsp_keys_waiting,
   output logic       rsp_overflow,
   output logic [9:0] rsp_mouse_x,
   output logic [8:0] rsp_mouse_y,
   output logic       rsp_left_button,
   output logic       rsp_right_button,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [9:0] csr_wdata
);
   import kmbd_pkg::*;

   logic [7:0] header_ff;
   logic [9:0] max_x_ff;
   logic [8:0] max_y_ff;
   logic [3:0] period_ff;

   logic    fifo_full, cmd_push, cmd_pop, head_valid;
   cmd_type push_cmd, head_cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= HEADER_PATTERN_RESET;
         max_x_ff  <= MAX_X_RESET;
         max_y_ff  <= MAX_Y_RESET;
         period_ff <= REPEAT_PERIOD_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_HEADER_PATTERN: header_ff <= csr_wdata[7:0];
            CSR_MAX_X:          max_x_ff  <= csr_wdata;
            CSR_MAX_Y:          max_y_ff  <= csr_wdata[8:0];
            CSR_REPEAT_PERIOD:  period_ff <= csr_wdata[3:0];
            default:            period_ff <= period_ff;
         endcase
      end
   end

   kmbd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_data       (req_data),
      .header_pattern (header_ff),
      .max_x          (max_x_ff),
      .max_y          (max_y_ff),
      .fifo_full      (fifo_full),
      .cmd_push       (cmd_push),
      .cmd            (push_cmd)
   );

   kmbd_cmd_fifo u_cmd_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_cmd   (push_cmd),
      .full       (fifo_full),
      .pop        (cmd_pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   kmbd_back #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (head_valid),
      .cmd              (head_cmd),
      .cmd_pop          (cmd_pop),
      .repeat_period    (period_ff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_key_valid    (rsp_key_valid),
      .rsp_key_code     (rsp_key_code),
      .rsp_keys_waiting (rsp_keys_waiting),
      .rsp_overflow     (rsp_overflow),
      .rsp_mouse_x      (rsp_mouse_x),
      .rsp_mouse_y      (rsp_mouse_y),
      .rsp_left_button  (rsp_left_button),
      .rsp_right_button (rsp_right_button)
   );

endmodule

// File: design/kmbd_checker.sv
// port level checks of the keyboard and mouse byte decoder, bound to the top level
// depends on keyboard_mouse_byte_decoder

module kmbd_checker #(
   parameter int QUEUE_DEPTH = 128
) (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_key_valid,
   input logic [6:0] rsp_key_code,
   input logic [7:0] rsp_keys_waiting,
   input logic       rsp_overflow
);

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_key_code) &&
      $stable(rsp_keys_waiting))
      else $error("stalled response changed");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // empty pop reports a zero code, a pop never drops a key
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_key_valid || rsp_key_code == 7'd0) &&
      !(rsp_key_valid && rsp_overflow))
      else $error("bad pop response");

   // a dropped key means the queue is full
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_keys_waiting == 8'(QUEUE_DEPTH))
      else $error("overflow with queue not full");

endmodule

bind keyboard_mouse_byte_decoder kmbd_checker #(
   .QUEUE_DEPTH(QUEUE_DEPTH)
) u_kmbd_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_key_valid    (rsp_key_valid),
   .rsp_key_code     (rsp_key_code),
   .rsp_keys_waiting (rsp_keys_waiting),
   .rsp_overflow     (rsp_overflow)
);

// File: test/keyboard_mouse_byte_decoder_test.sv
// self-checking bench for keyboard_mouse_byte_decoder: predicts every response and compares it
// field by field. depends on kmbd_pkg and the decoder rtl

module keyboard_mouse_byte_decoder_test;
   timeunit 1ns;
   timeprecision 1ps;

   import kmbd_pkg::*;

   localparam int          CLOCK_PERIOD = 12;
   localparam int          KEY_DEPTH    = 128;
   localparam int          CYCLE_LIMIT  = 200000;
   localparam logic [1:0]  FUNC_UNUSED  = 2'd3;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] data;
   } byte_request_type;

   typedef struct packed {
      logic       key_valid;
      logic [6:0] key_code;
      logic [7:0] keys_waiting;
      logic       overflow;
      logic [9:0] mouse_x;
      logic [8:0] mouse_y;
      logic       left_button;
      logic       right_button;
   } decoder_report_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_func = FUNC_BYTE;
   logic [7:0] req_data = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_key_valid;
   logic [6:0] rsp_key_code;
   logic [7:0] rsp_keys_waiting;
   logic       rsp_overflow;
   logic [9:0] rsp_mouse_x;
   logic [8:0] rsp_mouse_y;
   logic       rsp_left_button;
   logic       rsp_right_button;
   logic       csr_we = 1'b0;
   logic [1:0] csr_index = CSR_HEADER_PATTERN;
   logic [9:0] csr_wdata = '0;

   // decoder state as predicted
   logic [6:0] key_backlog [KEY_DEPTH];
   int         backlog_head = 0;
   int         backlog_tail = 0;
   int         backlog_fill = 0;
   logic       key_dropped;
   logic       slot_held [2] = '{1'b0, 1'b0};
   logic [6:0] slot_code [2] = '{7'd0, 7'd0};
   logic [3:0] slot_count [2] = '{4'd0, 4'd0};
   logic [9:0] cursor_x = POS_X_RESET;
   logic [8:0] cursor_y = POS_Y_RESET;
   logic       button_left = 1'b0;
   logic       button_right = 1'b0;
   logic [1:0] packet_step = PHASE_HEADER;

   logic [7:0] cfg_header = HEADER_PATTERN_RESET;
   logic [9:0] cfg_max_x = MAX_X_RESET;
   logic [8:0] cfg_max_y = MAX_Y_RESET;
   logic [3:0] cfg_period = REPEAT_PERIOD_RESET;

   byte_request_type   pending_requests [$];
   decoder_report_type decoded_results [$];
   decoder_report_type want;
   logic [6:0]         key_pool [4];

   int   requests_queued = 0;
   int   responses_seen = 0;
   int   issued_count = 0;
   int   accepted_count = 0;
   int   mismatch_count = 0;
   int   cycle_count = 0;
   int   burst_left = 1;
   int   gap_left = 0;
   logic [15:0] stall_bits = 16'hFFFF;
   logic [5:0]  stall_step = '0;
   logic        full_speed = 1'b1;

   keyboard_mouse_byte_decoder #(
      .QUEUE_DEPTH(KEY_DEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_func(req_func),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_key_valid(rsp_key_valid),
      .rsp_key_code(rsp_key_code),
      .rsp_keys_waiting(rsp_keys_waiting),
      .rsp_overflow(rsp_overflow),
      .rsp_mouse_x(rsp_mouse_x),
      .rsp_mouse_y(rsp_mouse_y),
      .rsp_left_button(rsp_left_button),
      .rsp_right_button(rsp_right_button),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic void backlog_push(logic [6:0] code);
      if (backlog_fill >= KEY_DEPTH) begin
         key_dropped = 1'b1;
      end else begin
         key_backlog[backlog_tail] = code;
         backlog_tail = (backlog_tail + 1) % KEY_DEPTH;
         backlog_fill++;
      end
   endfunction

   function automatic int clamp_step(int pos, logic [7:0] delta, int limit);
      int moved;
      moved = pos + int'($signed(delta));
      if (moved < 0) return 0;
      if (moved > limit) return limit;
      return moved;
   endfunction

   function automatic decoder_report_type decode_request(logic [1:0] func, logic [7:0] data);
      decoder_report_type r;
      r = '0;
      key_dropped = 1'b0;
      case (func)
         FUNC_BYTE: begin
            if ((data & cfg_header) == cfg_header || packet_step != PHASE_HEADER) begin
               case (packet_step)
                  PHASE_HEADER: begin
                     button_left = data[1];
                     button_right = data[0];
                     packet_step = PHASE_X;
                  end
                  PHASE_X: begin
                     cursor_x = 10'(clamp_step(int'(cursor_x), data, int'(cfg_max_x)));
                     packet_step = PHASE_Y;
                  end
                  default: begin
                     if (packet_step == PHASE_Y)
                        cursor_y = 9'(clamp_step(int'(cursor_y), data, int'(cfg_max_y)));
                     packet_step = PHASE_HEADER;
                  end
               endcase
            end else if (!data[7]) begin
               if (!slot_held[0]) begin
                  slot_code[0] = data[6:0];
                  slot_held[0] = 1'b1;
               end else begin
                  slot_code[1] = data[6:0];
                  slot_held[1] = 1'b1;
               end
               backlog_push(data[6:0]);
            end else if (data[6:0] == slot_code[0]) begin
               slot_held[0] = 1'b0;
            end else if (data[6:0] == slot_code[1]) begin
               slot_held[1] = 1'b0;
            end
         end
         FUNC_TICK: begin
            for (int s = 0; s < 2; s++) begin
               if (!slot_held[s]) begin
                  slot_count[s] = '0;
               end else if (slot_count[s] < cfg_period) begin
                  slot_count[s] = slot_count[s] + 4'd1;
               end else begin
                  slot_count[s] = '0;
                  backlog_push(slot_code[s]);
               end
            end
         end
         FUNC_POP: begin
            if (backlog_fill > 0) begin
               r.key_valid = 1'b1;
               r.key_code = key_backlog[backlog_head];
               backlog_head = (backlog_head + 1) % KEY_DEPTH;
               backlog_fill--;
            end
         end
         default: ;
      endcase
      r.keys_waiting = 8'(backlog_fill);
      r.overflow = key_dropped;
      r.mouse_x = cursor_x;
      r.mouse_y = cursor_y;
      r.left_button = button_left;
      r.right_button = button_right;
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      $display("mismatch at response %0d: %s", responses_seen, msg);
      mismatch_count++;
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] expected);
      if (got !== expected)
         report_mismatch($sformatf("%s got %0d expected %0d", name, got, expected));
   endtask

   // request acceptance, response checking and the run limit
   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         cycle_count++;
         if (!reset && req_valid && req_ready) begin
            decoded_results.push_back(decode_request(req_func, req_data));
            accepted_count++;
         end
         if (!reset && rsp_valid && rsp_ready) begin
            if (decoded_results.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               want = decoded_results.pop_front();
               check_field("key_valid", 32'(rsp_key_valid), 32'(want.key_valid));
               check_field("key_code", 32'(rsp_key_code), 32'(want.key_code));
               check_field("keys_waiting", 32'(rsp_keys_waiting), 32'(want.keys_waiting));
               check_field("overflow", 32'(rsp_overflow), 32'(want.overflow));
               check_field("mouse_x", 32'(rsp_mouse_x), 32'(want.mouse_x));
               check_field("mouse_y", 32'(rsp_mouse_y), 32'(want.mouse_y));
               check_field("left_button", 32'(rsp_left_button), 32'(want.left_button));
               check_field("right_button", 32'(rsp_right_button), 32'(want.right_button));
               responses_seen++;
            end
         end
      end
   end

   // request driver: bursts of random length separated by random gaps that may be empty
   always @(negedge clock) begin
      if (!reset && !(req_valid && accepted_count != issued_count)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            {req_func, req_data} <= pending_requests.pop_front();
            req_valid <= 1'b1;
            issued_count++;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 7);
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response stall pattern, reloaded whenever the six-bit stall_step wraps
   always @(negedge clock) begin
      if (stall_step == 6'd63) begin
         stall_bits = 16'($urandom);
         full_speed = ($urandom_range(3) == 0);
      end
      stall_step = stall_step + 6'd1;
      rsp_ready <= full_speed || stall_bits[stall_step[3:0]];
   end

   task automatic add_request(logic [1:0] func, logic [7:0] data);
      pending_requests.push_back({func, data});
      requests_queued++;
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (responses_seen != requests_queued);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] index, logic [9:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
   endtask

   task automatic apply_config(logic [7:0] header, logic [9:0] max_x, logic [8:0] max_y,
                               logic [3:0] period);
      write_csr(CSR_HEADER_PATTERN, 10'(header));
      write_csr(CSR_MAX_X, max_x);
      write_csr(CSR_MAX_Y, 10'(max_y));
      write_csr(CSR_REPEAT_PERIOD, 10'(period));
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_header = header;
      cfg_max_x = max_x;
      cfg_max_y = max_y;
      cfg_period = period;
   endtask

   function automatic logic [7:0] pick_delta();
      case ($urandom_range(5))
         0: return 8'h7F;
         1: return 8'h80;
         default: return 8'($urandom);
      endcase
   endfunction

   // mostly whole mouse packets and single makes and breaks on a small code pool
   task automatic queue_random_items(int count);
      int roll;
      logic [6:0] code;
      for (int s = 0; s < 4; s++)
         key_pool[s] = 7'($urandom);
      while (count > 0) begin
         roll = $urandom_range(99);
         code = ($urandom_range(7) == 0) ? 7'($urandom) : key_pool[$urandom_range(3)];
         if (roll < 30) begin
            add_request(FUNC_BYTE, cfg_header | 8'($urandom));
            add_request(FUNC_BYTE, pick_delta());
            add_request(FUNC_BYTE, pick_delta());
            count -= 3;
         end else begin
            if (roll < 50)
               add_request(FUNC_BYTE, {1'b0, code});
            else if (roll < 62)
               add_request(FUNC_BYTE, {1'b1, code});
            else if (roll < 78)
               add_request(FUNC_TICK, 8'($urandom));
            else if (roll < 95)
               add_request(FUNC_POP, 8'($urandom));
            else if (roll < 97)
               add_request(FUNC_UNUSED, 8'($urandom));
            else
               add_request(FUNC_BYTE, 8'($urandom));
            count--;
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: mouse packets at the delta extremes, slot handling, repeat, pop
      add_request(FUNC_BYTE, 8'hFB);
      add_request(FUNC_BYTE, 8'h7F);
      add_request(FUNC_BYTE, 8'h80);
      add_request(FUNC_BYTE, 8'hF8);
      add_request(FUNC_BYTE, 8'h80);
      add_request(FUNC_BYTE, 8'h00);
      add_request(FUNC_BYTE, 8'h1E);
      add_request(FUNC_BYTE, 8'h30);
      add_request(FUNC_BYTE, 8'h80);
      add_request(FUNC_BYTE, 8'hB0);
      add_request(FUNC_BYTE, 8'h7F);
      repeat (10) add_request(FUNC_TICK, 8'hFF);
      add_request(FUNC_POP, 8'h00);
      add_request(FUNC_UNUSED, 8'hA5);
      wait_idle();

      // fill the key queue through fast repeat, then overflow, then drain past empty
      apply_config(8'hF8, 10'd1023, 9'd511, 4'd0);
      add_request(FUNC_BYTE, 8'h11);
      add_request(FUNC_BYTE, 8'h22);
      repeat (66) add_request(FUNC_TICK, 8'h00);
      add_request(FUNC_BYTE, 8'h33);
      add_request(FUNC_BYTE, 8'h91);
      repeat (4) add_request(FUNC_TICK, 8'h00);
      repeat (131) add_request(FUNC_POP, 8'($urandom));
      queue_random_items(60);
      wait_idle();

      apply_config(8'hFF, 10'd1, 9'd1, 4'd15);
      queue_random_items(220);
      wait_idle();

      apply_config(8'h00, 10'($urandom_range(1, 1023)), 9'($urandom_range(1, 511)),
                   4'($urandom));
      queue_random_items(100);
      wait_idle();

      apply_config(8'($urandom), 10'($urandom_range(1, 1023)), 9'($urandom_range(1, 511)),
                   4'd3);
      queue_random_items(240);
      wait_idle();

      apply_config(HEADER_PATTERN_RESET, MAX_X_RESET, MAX_Y_RESET, REPEAT_PERIOD_RESET);
      queue_random_items(300);
      wait_idle();

      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
